@@ src/hfdl_pkg.sv @@
// ----------------------------------------------------------------------------
// hfdl_pkg: shared types and constants for the Hermite fractional delay line
// Holds default parameter values, the controller state type and the command
// bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package hfdl_pkg;

  localparam int DEPTH_DEF         = 65536;
  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int DELAY_WIDTH       = 32;

  // Tap and Horner step codes carried on the 2-bit select fields
  localparam logic [1:0] TAP_FIRST   = 2'd0;
  localparam logic [1:0] TAP_LAST    = 2'd3;
  localparam logic [1:0] STEP_ADD_B  = 2'd0;
  localparam logic [1:0] STEP_ADD_C  = 2'd1;
  localparam logic [1:0] STEP_LAST   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_DRAIN,
    ST_COEF,
    ST_MAC,
    ST_DONE
  } hfdl_state_e;

  typedef struct packed {
    logic       load;     // capture input transaction
    logic       addr;     // clamp delay, form read position
    logic       rd;       // issue a tap read
    logic [1:0] tap;      // tap being read
    logic       cap;      // capture read data
    logic [1:0] cap_idx;  // tap slot for captured data
    logic       coef;     // form Hermite coefficients
    logic       wr;       // store new sample, advance write pointer
    logic       mac;      // one Horner step
    logic [1:0] step;     // Horner step number
    logic       fin;      // round, saturate, load output register
  } hfdl_cmd_t;

endpackage

@@ src/hfdl_ram.sv @@
// ----------------------------------------------------------------------------
// hfdl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hfdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/hfdl_ctrl.sv @@
// ----------------------------------------------------------------------------
// hfdl_ctrl: sequencer for the Hermite fractional delay line
// Steps one transaction through address, tap reads, coefficients, Horner
// steps and output; owns the input stall and output valid.
// ----------------------------------------------------------------------------
module hfdl_ctrl
  import hfdl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hfdl_cmd_t cmd_o
);

  hfdl_state_e state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= TAP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        cnt_d      = TAP_FIRST;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd      = 1'b1;
        cmd_o.tap     = cnt_q;
        cmd_o.cap     = (cnt_q != TAP_FIRST);
        cmd_o.cap_idx = cnt_q - 2'd1;
        cnt_d         = cnt_q + 2'd1;
        if (cnt_q == TAP_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.cap     = 1'b1;
        cmd_o.cap_idx = TAP_LAST;
        state_d       = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        cmd_o.wr   = 1'b1;
        cnt_d      = STEP_ADD_B;
        state_d    = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac  = 1'b1;
        cmd_o.step = cnt_q;
        cnt_d      = cnt_q + 2'd1;
        if (cnt_q == STEP_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/hfdl_datapath.sv @@
// ----------------------------------------------------------------------------
// hfdl_datapath: sample store and arithmetic of the delay line
// Read-position math, tap store with written-region tracking, Hermite
// coefficients, shared Horner multiplier, rounding and saturation.
// ----------------------------------------------------------------------------
module hfdl_datapath
  import hfdl_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hfdl_cmd_t                      cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [DELAY_WIDTH-1:0]         delay_amount_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int FB  = FRACTION_BITS;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = AW + FB + 1;
  localparam int CW  = (DELAY_WIDTH > PW) ? DELAY_WIDTH : PW;
  localparam int ACW = SW + 5;
  localparam int PRW = ACW + FB + 1;
  localparam int TW  = AW + 2;

  localparam logic [CW-1:0] DMIN  = CW'(1) << FB;
  localparam logic [CW-1:0] DMAX  = CW'(DEPTH - 4) << FB;
  localparam logic [PW-1:0] SPAN  = PW'(DEPTH) << FB;
  localparam logic [TW-1:0] WRAP1 = TW'(DEPTH);
  localparam logic [TW-1:0] WRAP2 = TW'(2 * DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW - 1){1'b0}}};

  logic signed [SW-1:0]  sample_q;
  logic [DELAY_WIDTH-1:0] delay_q;
  logic [AW-1:0]          base_q;
  logic [FB-1:0]          frac_q;
  logic [AW-1:0]          wp_q;
  logic                   full_q;
  logic                   tap_ok_q;
  logic signed [SW-1:0]   y_q [4];
  logic signed [ACW-1:0]  acc_q, b_q, c_q;
  logic signed [SW-1:0]   out_q;

  // read position
  logic [CW-1:0] d_ext, d_clamp;
  logic [PW-1:0] rp_raw, rp_wrap;

  assign d_ext   = CW'(delay_q);
  assign d_clamp = (d_ext < DMIN) ? DMIN : ((d_ext > DMAX) ? DMAX : d_ext);
  assign rp_raw  = {1'b0, wp_q, {FB{1'b0}}} - PW'(d_clamp);
  assign rp_wrap = rp_raw[PW-1] ? (rp_raw + SPAN) : rp_raw;

  // tap address, base + tap - 1 modulo DEPTH
  logic [TW-1:0] tap_sum, tap_wrap;
  logic [AW-1:0] tap_addr;
  logic          tap_ok_d;

  assign tap_sum  = TW'(base_q) + TW'(cmd_i.tap) + TW'(DEPTH - 1);
  always_comb begin
    if (tap_sum >= WRAP2) begin
      tap_wrap = tap_sum - WRAP2;
    end else if (tap_sum >= WRAP1) begin
      tap_wrap = tap_sum - WRAP1;
    end else begin
      tap_wrap = tap_sum;
    end
  end
  assign tap_addr = tap_wrap[AW-1:0];
  // entries not yet written since reset read as zero
  assign tap_ok_d = full_q || (tap_addr < wp_q);

  logic [SW-1:0] rdata;

  hfdl_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.rd),
    .raddr_i (tap_addr),
    .rdata_o (rdata)
  );

  // coefficients (doubled, exact)
  logic signed [ACW-1:0] ye0, ye1, ye2, ye3, a_d, b_d, c_d;

  assign ye0 = ACW'(y_q[0]);
  assign ye1 = ACW'(y_q[1]);
  assign ye2 = ACW'(y_q[2]);
  assign ye3 = ACW'(y_q[3]);
  assign a_d = (ye3 - ye0) + (ye1 - ye2) + (ye1 - ye2) + (ye1 - ye2);
  assign b_d = ye0 + ye0 - (ye1 <<< 2) - ye1 + (ye2 <<< 2) - ye3;
  assign c_d = ye2 - ye0;

  // Horner step: acc = floor(acc * f / 2^FB) + addend
  logic signed [FB:0]     f_s;
  logic signed [PRW-1:0]  prod, prod_shf;
  logic signed [ACW-1:0]  addend, acc_d;

  assign f_s      = signed'({1'b0, frac_q});
  assign prod     = acc_q * f_s;
  assign prod_shf = prod >>> FB;
  always_comb begin
    case (cmd_i.step)
      STEP_ADD_B: addend = b_q;
      STEP_ADD_C: addend = c_q;
      default:    addend = '0;
    endcase
  end
  assign acc_d = ACW'(prod_shf) + addend;

  // round half up, add y1, saturate
  logic signed [ACW-1:0] half, res;
  logic                  fits;
  logic signed [SW-1:0]  out_d;

  assign half  = (acc_q + ACW'(1)) >>> 1;
  assign res   = ye1 + half;
  assign fits  = (res[ACW-1:SW-1] == {(ACW - SW + 1){res[SW-1]}});
  assign out_d = fits ? res[SW-1:0] : (res[ACW-1] ? SMIN : SMAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.wr) begin
      if (wp_q == WP_LAST) begin
        wp_q   <= '0;
        full_q <= 1'b1;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_in_i;
      delay_q  <= delay_amount_i;
    end
    if (cmd_i.addr) begin
      base_q <= rp_wrap[AW+FB-1:FB];
      frac_q <= rp_wrap[FB-1:0];
    end
    if (cmd_i.rd) begin
      tap_ok_q <= tap_ok_d;
    end
    if (cmd_i.cap) begin
      y_q[cmd_i.cap_idx] <= tap_ok_q ? signed'(rdata) : '0;
    end
    if (cmd_i.coef) begin
      acc_q <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
    end else if (cmd_i.mac) begin
      acc_q <= acc_d;
    end
    if (cmd_i.fin) begin
      out_q <= out_d;
    end
  end

  assign sample_out_o = out_q;

endmodule

@@ src/hermite_fractional_delay_line.sv @@
// ----------------------------------------------------------------------------
// hermite_fractional_delay_line: circular delay with 4-point Hermite readout
// Top level: sequencer plus datapath around a single-port-read sample store.
// ----------------------------------------------------------------------------
// Each transaction brings one Q1.(SAMPLE_WIDTH-1) sample and a delay in
// samples with FRACTION_BITS fraction bits; the delay is clamped to
// 1 .. DEPTH-4. The block reads four consecutive taps around the write
// pointer minus the delay (wrapping modulo DEPTH), stores the new sample
// and advances the write pointer, then interpolates with a Catmull-Rom
// Hermite cubic by Horner's rule, rounds half up and saturates. One result
// comes out per transaction. A transaction steps through one address
// state, four tap reads through the store's one read port plus a drain
// state for its registered read data, one coefficient state, three Horner
// steps on one shared multiplier, one output state and the idle state in
// which the next transaction is taken.
// The output sits in its own register, so the next transaction is taken
// while a result still waits under out_stall_i; if that result is still
// waiting when the next one is ready, the output cycle holds until it is
// taken. The store is not swept after
// reset: a write pointer plus a wrapped flag tracks which entries were
// written, and unwritten entries read as zero, so the block is ready as
// soon as reset is released.
// ----------------------------------------------------------------------------
module hermite_fractional_delay_line
  import hfdl_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [DELAY_WIDTH-1:0]         delay_amount_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  hfdl_cmd_t cmd;

  // sequencer: one transaction at a time
  hfdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // store, position math, interpolation arithmetic
  hfdl_datapath #(
    .DEPTH         (DEPTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_in_i    (sample_in_i),
    .delay_amount_i (delay_amount_i),
    .sample_out_o   (sample_out_o)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for hermite_fractional_delay_line
// Drives sample/delay transactions with random gaps and output stalls. A
// scoreboard keeps its own copy of the tape and the write pointer, predicts
// each interpolated sample and checks the results in order.
// ----------------------------------------------------------------------------
module tb;
  import hfdl_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int SW             = SAMPLE_WIDTH_DEF;
  localparam int FB             = FRACTION_BITS_DEF;
  localparam int SMAX           = (1 << (SW - 1)) - 1;
  localparam int SMIN           = -SMAX - 1;
  localparam int MAX_GAP        = 11;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int HOLD_AFTER     = 350;   // input count that triggers it
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 40;    // idle time after the last result is checked
  localparam int PHASE_ITEMS    = 275;   // 4 phases, ~1100 random items

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Scoreboard: owns the predicted tape, write pointer and expected samples
  // --------------------------------------------------------------------------
  class delay_line_scoreboard;
    int tape [DEPTH];
    int unsigned wr_ptr;
    logic signed [SW-1:0] expected_samples [$];
    int mismatches;
    int results_checked;
    int saturated;

    // Predict the interpolated tap read for this transaction, then store
    // the new sample and advance the pointer.
    function void note_input(int s, longint unsigned d);
      longint unsigned unit, top, span, pos, base, frac;
      longint y [4];
      longint a, b, c, acc, r;
      int k;
      unit = 64'd1 << FB;
      top  = 64'(DEPTH - 4) << FB;
      span = 64'(DEPTH) << FB;
      if (d < unit) d = unit;
      if (d > top) d = top;
      pos = (64'(wr_ptr) << FB) + span - d;
      if (pos >= span) pos -= span;
      base = pos >> FB;
      frac = pos & (unit - 1);
      for (k = 0; k < 4; k++) begin
        y[k] = tape[int'((base + DEPTH + k - 1) % DEPTH)];
      end
      // doubled Catmull-Rom coefficients, exact integers
      a = (y[3] - y[0]) + 3 * (y[1] - y[2]);
      b = 2 * y[0] - 5 * y[1] + 4 * y[2] - y[3];
      c = y[2] - y[0];
      // Horner; >>> on signed values floors
      acc = ((a * longint'(frac)) >>> FB) + b;
      acc = ((acc * longint'(frac)) >>> FB) + c;
      acc = (acc * longint'(frac)) >>> FB;
      r = y[1] + ((acc + 1) >>> 1);
      if (r > SMAX) begin
        r = SMAX;
        saturated++;
      end else if (r < SMIN) begin
        r = SMIN;
        saturated++;
      end
      expected_samples.push_back(SW'(r));
      tape[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % DEPTH;
    endfunction

    function void check_result(logic signed [SW-1:0] actual);
      logic signed [SW-1:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: unexpected result sample_out=%0d", $realtime, actual);
        return;
      end
      want = expected_samples.pop_front();
      results_checked++;
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: sample_out mismatch, expected %0d (0x%h) got %0d (0x%h)",
                   $realtime, want, want, actual, actual);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input known from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic signed [SW-1:0]   sample_in_i    = '0;
  logic [DELAY_WIDTH-1:0] delay_amount_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b1;
  logic signed [SW-1:0]   sample_out_o;

  delay_line_scoreboard board;

  // bench control
  bit in_idle   = 1'b1;  // sender draws random gaps
  bit out_idle  = 1'b1;  // receiver draws random stalls
  bit hold_off  = 1'b0;  // long receiver hold-off in progress
  int in_count  = 0;     // accepted input transactions
  int n_directed;
  int out_wait  = 0;
  int quiet_cycles = 0;

  hermite_fractional_delay_line u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .delay_amount_i (delay_amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Sender: one transaction per call. Called at a rising edge, returns at the
  // edge where the transaction was taken. Valid is only touched once per
  // step, so back-to-back items keep it high without a glitch.
  // --------------------------------------------------------------------------
  task automatic push_sample(input logic signed [SW-1:0] s,
                             input logic [DELAY_WIDTH-1:0] d);
    int gap;
    gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_in_i    <= s;
    delay_amount_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(int'(s), d);
    in_count++;
  endtask

  // Mostly full-range audio, with the rails and near-zero values mixed in
  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SW'($urandom_range(0, 511)) - SW'(256);
      default: return SW'($urandom);
    endcase
  endfunction

  // Delay mix: short delays read back freshly written history, the others
  // hit the clamps, whole-sample and near-whole fractions, and long reads
  // into older or never-written parts of the tape.
  function automatic logic [DELAY_WIDTH-1:0] rand_delay();
    case ($urandom_range(0, 9))
      4:       return $urandom;
      5:       return 32'hFFF0_0000 | ($urandom & 32'h000F_FFFF);
      6:       return $urandom & 32'h0000_FFFF;
      7:       return {16'($urandom_range(1, 200)), 16'h0000};
      8:       return {16'($urandom_range(1, 200)), 16'hFFFF};
      9:       return {16'($urandom_range(25, 1200)), 16'($urandom)};
      default: return {16'($urandom_range(1, 24)), 16'($urandom)};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver and result check. The stall count drawn per result only runs
  // down while a result is actually offered, so stalls land on it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_result(sample_out_o);
        out_wait = out_idle ? $urandom_range(0, MAX_GAP) : 0;
      end else if (out_valid_o && out_wait > 0) begin
        out_wait--;
      end
      out_stall_i <= hold_off || (out_wait > 0);
    end
  end

  // Long hold-off in its own process: the sender keeps offering with no gaps
  // (phase two), so the output register and the pipeline fill and the input
  // side has to stall.
  initial begin
    wait (in_count >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog: any stretch without a transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction, %0d results pending",
                 quiet_cycles, board.pending());
        $display("hermite_fractional_delay_line regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph, i;
    board = new;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clamps, fraction extremes, rail samples and both overshoots.
    // Tape fills max,min,min,max at 0..3; a 2.5-sample delay then centers the
    // cubic on the two mins and it undershoots past the negative rail.
    push_sample(S_MAX, 32'h0000_0000);          // zero delay, raised to 1.0
    push_sample(S_MIN, 32'h0000_8000);          // half a sample, raised to 1.0
    push_sample(S_MIN, 32'h0001_0000);          // exactly one, zero fraction
    push_sample(S_MAX, 32'h0001_FFFF);          // largest fraction
    push_sample('0,    32'h0002_8000);          // low saturation
    // min,max,max,min at 5..8, then overshoot past the positive rail
    push_sample(S_MIN, 32'h0001_0000);
    push_sample(S_MAX, 32'h0001_0000);
    push_sample(S_MAX, 32'h0001_0000);
    push_sample(S_MIN, 32'h0001_0000);
    push_sample(S_MAX, 32'h0002_8000);          // high saturation
    push_sample(S_MAX, 32'hFFFF_FFFF);          // lowered to DEPTH-4
    push_sample(S_MIN, 32'hFFFC_0000);          // exactly DEPTH-4
    push_sample(SW'(1), 32'hFFFC_0001);         // just above the top clamp
    push_sample(-SW'(1), 32'hFFFB_FFFF);        // just below, full fraction
    push_sample('0,    32'h0000_FFFF);          // just under one sample
    push_sample(S_MAX, 32'h0001_0001);          // taps past the write pointer
    push_sample(S_MIN, 32'h000A_4000);          // deeper into written history
    push_sample(SW'(24'h555555), 32'h5555_5555);
    push_sample(SW'(24'hAAAAAA), 32'hAAAA_AAAA);
    push_sample(S_MAX, 32'h0003_C000);
    push_sample(S_MIN, 32'h0004_4000);
    n_directed = in_count;

    // Random phases: both idle, none idle (hold-off lands here),
    // sender idle only, receiver idle only.
    for (ph = 0; ph < 4; ph++) begin
      in_idle  = (ph == 0) || (ph == 2);
      out_idle <= (ph == 0) || (ph == 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        push_sample(rand_sample(), rand_delay());
      end
    end
    in_valid_i <= 1'b0;

    // Drain; a result that never comes trips the watchdog
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (%0d directed) with gaps, stalls and a %0d-cycle hold-off;",
             in_count, n_directed, HOLD_CYCLES);
    $display("checked %0d interpolated samples, %0d of them at a rail, %0d mismatches.",
             board.results_checked, board.saturated, board.mismatches);
    if (board.mismatches == 0) begin
      $display("hermite_fractional_delay_line regression: pass");
    end else begin
      $display("hermite_fractional_delay_line regression: fail");
    end
    $finish;
  end

endmodule
